/* design/sorted_table_insert_engine_macros.svh */
// Assertion macros shared by the sorted table insert engine.
`ifndef SORTED_TABLE_INSERT_ENGINE_MACROS_SVH
`define SORTED_TABLE_INSERT_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and off while rst_ni is low.
`define STIE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and off while rst_ni is low.
`define STIE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/stie_pkg.sv */
// Types and operation, policy and status codes of the sorted table insert engine.
package stie_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [3:0] policy_t;
  typedef logic [2:0] status_t;

  // Operation codes.
  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_DELETE = 2'd1;
  localparam mode_t MODE_READ   = 2'd2;
  localparam mode_t MODE_CLEAR  = 2'd3;

  // Insert policies; every other code behaves as a plain sorted insert.
  localparam policy_t POL_UNIQUE       = 4'd1;
  localparam policy_t POL_DUPLICATE    = 4'd2;
  localparam policy_t POL_BEFORE_FIRST = 4'd3;
  localparam policy_t POL_AFTER_LAST   = 4'd4;
  localparam policy_t POL_UPD_FIRST    = 4'd5;
  localparam policy_t POL_UPD_LAST     = 4'd6;
  localparam policy_t POL_UPD_ALL      = 4'd7;
  localparam policy_t POL_UPSERT_FIRST = 4'd8;
  localparam policy_t POL_UPSERT_LAST  = 4'd9;

  // Result status codes.
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_BAD_INDEX = 3'd1;
  localparam status_t ST_NOT_FOUND = 3'd2;
  localparam status_t ST_EXISTS    = 3'd3;
  localparam status_t ST_FULL      = 3'd4;

endpackage

/* design/sorted_table_insert_engine.sv */
// Top level of the sorted table insert engine: sequencer, compare unit and table RAM.
//
// The engine keeps up to DEPTH key/value entries in ascending unsigned key order in
// one RAM with a single write port and a single registered read port, and runs one
// transaction at a time. A sorted insert scans the filled entries one per cycle
// through a single key comparator, then moves the entries above the insert point up
// one slot per cycle and writes the new entry; an entry that goes at the end moves
// nothing. Update-all rewrites one matching entry per cycle after the scan. A delete
// reads the entry and moves the entries above it down one per cycle. The single RAM
// port pair and the one comparator set these rates. in_ready_o is high only while no
// transaction is in work; a finished result waits in the output register while the
// next transaction is accepted. capacity_limit resets to DEPTH and values above DEPTH
// act as DEPTH.
`include "sorted_table_insert_engine_macros.svh"

module sorted_table_insert_engine #(
  parameter int DEPTH      = 16,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port for capacity_limit.
  input  logic                            cfg_we_i,
  input  logic [$clog2(DEPTH+1)-1:0]      cfg_wdata_i,
  // Input channel.
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  stie_pkg::mode_t                 mode_i,
  input  stie_pkg::policy_t               policy_i,
  input  logic [$clog2(DEPTH)-1:0]        position_i,
  input  logic [KEY_BITS-1:0]             new_key_i,
  input  logic [VALUE_BITS-1:0]           new_value_i,
  // Output channel.
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output stie_pkg::status_t               status_o,
  output logic [KEY_BITS-1:0]             out_key_o,
  output logic [VALUE_BITS-1:0]           out_value_o,
  output logic [$clog2(DEPTH)-1:0]        where_written_o,
  output logic [$clog2(DEPTH+1)-1:0]      entries_now_o
);

  import stie_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int ENT_W = KEY_BITS + VALUE_BITS;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DECIDE = 4'd2;
  localparam logic [3:0] S_SHUP   = 4'd3;
  localparam logic [3:0] S_PUT    = 4'd4;
  localparam logic [3:0] S_UPALL  = 4'd5;
  localparam logic [3:0] S_RDPOS  = 4'd6;
  localparam logic [3:0] S_SHDN   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // Control state.
  logic [3:0]            state_q, state_d;
  logic [CNT_W-1:0]      cap_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q, out_valid_d;

  // Transaction and work registers.
  mode_t                 mode_q, mode_d;
  policy_t               pol_q, pol_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic [IDX_W-1:0]      first_q, first_d;
  logic [IDX_W-1:0]      last_q, last_d;
  logic [CNT_W-1:0]      gt_q, gt_d;
  logic                  found_q, found_d;
  logic                  gt_seen_q, gt_seen_d;
  logic [CNT_W-1:0]      at_q, at_d;
  status_t               res_status_q, res_status_d;
  logic [KEY_BITS-1:0]   res_key_q, res_key_d;
  logic [VALUE_BITS-1:0] res_val_q, res_val_d;
  logic [IDX_W-1:0]      res_where_q, res_where_d;

  // Output register.
  status_t               out_status_q;
  logic [KEY_BITS-1:0]   out_key_q;
  logic [VALUE_BITS-1:0] out_val_q;
  logic [IDX_W-1:0]      out_where_q;
  logic [CNT_W-1:0]      out_count_q;
  logic                  out_load;

  // RAM port signals.
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;

  // Shared compare unit and derived conditions.
  logic                  key_eq;
  logic                  key_gt;
  logic [CNT_W-1:0]      idx_inc;
  logic [CNT_W-1:0]      idx_inc2;
  logic [CNT_W-1:0]      idx_dec;
  logic [CNT_W-1:0]      idx_dec2;
  logic [CNT_W-1:0]      count_inc;
  logic [CNT_W-1:0]      count_dec;
  logic                  pol_first_kind;
  logic                  pol_last_kind;
  logic                  table_full;
  logic [CNT_W-1:0]      ins_at;

  stie_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key = ram_rdata[ENT_W-1 -: KEY_BITS];
  assign rd_val = ram_rdata[VALUE_BITS-1:0];

  // One comparator serves the whole scan.
  assign key_eq = (rd_key == key_q);
  assign key_gt = (rd_key > key_q);

  assign idx_inc   = idx_q + CNT_W'(1);
  assign idx_inc2  = idx_q + CNT_W'(2);
  assign idx_dec   = idx_q - CNT_W'(1);
  assign idx_dec2  = idx_q - CNT_W'(2);
  assign count_inc = count_q + CNT_W'(1);
  assign count_dec = count_q - CNT_W'(1);

  // Policy grouping and insert point selection.
  assign pol_first_kind = (pol_q == POL_UPD_FIRST) || (pol_q == POL_UPSERT_FIRST);
  assign pol_last_kind  = (pol_q == POL_UPD_LAST) || (pol_q == POL_UPSERT_LAST);
  assign table_full     = (count_q >= cap_q) || (count_q >= CNT_W'(DEPTH));

  always_comb begin
    if (found_q && (pol_q == POL_BEFORE_FIRST)) begin
      ins_at = CNT_W'(first_q);
    end else if (found_q && ((pol_q == POL_DUPLICATE) || (pol_q == POL_AFTER_LAST))) begin
      ins_at = CNT_W'(last_q) + CNT_W'(1);
    end else begin
      ins_at = gt_q;
    end
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    mode_d       = mode_q;
    pol_d        = pol_q;
    pos_d        = pos_q;
    key_d        = key_q;
    val_d        = val_q;
    idx_d        = idx_q;
    first_d      = first_q;
    last_d       = last_q;
    gt_d         = gt_q;
    found_d      = found_q;
    gt_seen_d    = gt_seen_q;
    at_d         = at_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_val_d    = res_val_q;
    res_where_d  = res_where_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[IDX_W-1:0];
    ram_wdata    = {key_q, val_q};
    ram_raddr    = idx_inc[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        ram_raddr = (mode_i == MODE_INSERT) ? '0 : position_i;
        if (in_valid_i) begin
          mode_d       = mode_i;
          pol_d        = policy_i;
          pos_d        = position_i;
          key_d        = new_key_i;
          val_d        = new_value_i;
          idx_d        = '0;
          found_d      = 1'b0;
          gt_seen_d    = 1'b0;
          gt_d         = count_q;
          res_status_d = ST_OK;
          res_key_d    = '0;
          res_val_d    = '0;
          res_where_d  = '0;
          case (mode_i)
            MODE_INSERT: begin
              state_d = (count_q == '0) ? S_DECIDE : S_SCAN;
            end
            MODE_DELETE, MODE_READ: begin
              if (CNT_W'(position_i) >= count_q) begin
                res_status_d = ST_BAD_INDEX;
                state_d      = S_DONE;
              end else begin
                state_d = S_RDPOS;
              end
            end
            MODE_CLEAR: begin
              count_d = '0;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Compare one entry per cycle while the next one is read.
      S_SCAN: begin
        if (key_eq) begin
          if (!found_q) begin
            first_d = idx_q[IDX_W-1:0];
          end
          found_d = 1'b1;
          last_d  = idx_q[IDX_W-1:0];
        end
        if (key_gt && !gt_seen_q) begin
          gt_d      = idx_q;
          gt_seen_d = 1'b1;
        end
        if (idx_q == count_dec) begin
          state_d = S_DECIDE;
        end else begin
          idx_d = idx_inc;
        end
      end

      // Apply the policy to the scan result.
      S_DECIDE: begin
        ram_raddr = count_dec[IDX_W-1:0];
        state_d   = S_DONE;
        if (found_q && pol_first_kind) begin
          ram_we      = 1'b1;
          ram_waddr   = first_q;
          res_where_d = first_q;
        end else if (found_q && pol_last_kind) begin
          ram_we      = 1'b1;
          ram_waddr   = last_q;
          res_where_d = last_q;
        end else if (pol_q == POL_UPD_ALL) begin
          if (found_q) begin
            idx_d       = CNT_W'(first_q);
            res_where_d = first_q;
            state_d     = S_UPALL;
          end else begin
            res_status_d = ST_NOT_FOUND;
          end
        end else if (!found_q && ((pol_q == POL_UPD_FIRST) || (pol_q == POL_UPD_LAST))) begin
          res_status_d = ST_NOT_FOUND;
        end else if (found_q && (pol_q == POL_UNIQUE)) begin
          res_status_d = ST_EXISTS;
        end else if (!found_q && (pol_q == POL_DUPLICATE)) begin
          res_status_d = ST_NOT_FOUND;
        end else if (table_full) begin
          res_status_d = ST_FULL;
        end else begin
          at_d = ins_at;
          if (ins_at == count_q) begin
            ram_we      = 1'b1;
            ram_waddr   = count_q[IDX_W-1:0];
            res_where_d = count_q[IDX_W-1:0];
            count_d     = count_inc;
          end else begin
            idx_d   = count_q;
            state_d = S_SHUP;
          end
        end
      end

      // Move entries up one slot, top first.
      S_SHUP: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ram_raddr = idx_dec2[IDX_W-1:0];
        if (idx_dec == at_q) begin
          state_d = S_PUT;
        end else begin
          idx_d = idx_dec;
        end
      end

      // Write the new entry into the opened slot.
      S_PUT: begin
        ram_we      = 1'b1;
        ram_waddr   = at_q[IDX_W-1:0];
        res_where_d = at_q[IDX_W-1:0];
        count_d     = count_inc;
        state_d     = S_DONE;
      end

      // Rewrite every matching entry, one per cycle.
      S_UPALL: begin
        ram_we = 1'b1;
        if (idx_q[IDX_W-1:0] == last_q) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_inc;
        end
      end

      // The addressed entry is on the read port.
      S_RDPOS: begin
        res_key_d = rd_key;
        res_val_d = rd_val;
        ram_raddr = pos_q + IDX_W'(1);
        if (mode_q == MODE_READ) begin
          state_d = S_DONE;
        end else if (CNT_W'(pos_q) == count_dec) begin
          count_d = count_dec;
          state_d = S_DONE;
        end else begin
          idx_d   = CNT_W'(pos_q);
          state_d = S_SHDN;
        end
      end

      // Move entries down one slot, bottom first.
      S_SHDN: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ram_raddr = idx_inc2[IDX_W-1:0];
        if (idx_inc2 == count_q) begin
          count_d = count_dec;
          state_d = S_DONE;
        end else begin
          idx_d = idx_inc;
        end
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, cleared when the transaction is taken.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CNT_W'(DEPTH);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Work and result registers.
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    pol_q        <= pol_d;
    pos_q        <= pos_d;
    key_q        <= key_d;
    val_q        <= val_d;
    idx_q        <= idx_d;
    first_q      <= first_d;
    last_q       <= last_d;
    gt_q         <= gt_d;
    found_q      <= found_d;
    gt_seen_q    <= gt_seen_d;
    at_q         <= at_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_val_q    <= res_val_d;
    res_where_q  <= res_where_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_val_q    <= res_val_q;
      out_where_q  <= res_where_q;
      out_count_q  <= count_q;
    end
  end

  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_key_o       = out_key_q;
  assign out_value_o     = out_val_q;
  assign where_written_o = out_where_q;
  assign entries_now_o   = out_count_q;

  // The engine takes no new transaction in the cycle after it accepts one.
  `STIE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                    "accepted while busy")

  // The table is written only while a transaction is in work.
  `STIE_ASSERT_IMPL(a_write_when_busy, ram_we,
                    (state_q != S_IDLE) && (state_q != S_DONE),
                    "table write outside a transaction")

  // Apart from a clear, the entry count moves by exactly one.
  `STIE_ASSERT_IMPL(a_count_step,
                    (count_q != $past(count_q)) && ($past(state_q) != S_IDLE),
                    (count_q == $past(count_q) + CNT_W'(1)) ||
                    (count_q == $past(count_q) - CNT_W'(1)),
                    "entry count jumped")

endmodule

/* design/stie_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module stie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; a read returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/sorted_table_insert_engine_tb.sv */
// Self-checking testbench for the sorted table insert engine with its own table predictor.
module sorted_table_insert_engine_tb;
  import stie_pkg::*;

  localparam int DEPTH = 16;
  localparam int QUIET_CYCLES_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_PRINTED = 40;

  // Policy codes the package leaves unnamed: plain sorted insert and an unused code.
  localparam policy_t POL_ANY      = 4'd0;
  localparam policy_t POL_RESERVED = 4'd15;

  // Capacity settings per phase; a negative entry asks for a random setting.
  localparam int NUM_PHASES = 7;
  localparam int PHASE_CAP [NUM_PHASES]     = '{16, 4, 0, 31, 1, 8, -1};
  localparam int PHASE_ITEMS [NUM_PHASES]   = '{200, 100, 60, 200, 80, 120, 140};
  localparam int PHASE_INS_PCT [NUM_PHASES] = '{60, 45, 50, 60, 55, 55, 50};
  localparam int PHASE_IDLE [NUM_PHASES]    = '{14, 14, 14, 0, 14, 14, 14};

  typedef struct packed {
    mode_t         mode;
    policy_t       policy;
    logic [3:0]    position;
    logic [15:0]   key;
    logic [15:0]   value;
  } table_op_t;

  typedef struct packed {
    status_t       status;
    logic [15:0]   key;
    logic [15:0]   value;
    logic [3:0]    where;
    logic [4:0]    count;
  } table_reply_t;

  typedef struct packed {
    table_op_t     op;
    bit            typed;
    table_reply_t  want;
  } directed_row_t;

  // Directed rows; the reply is typed in only where it is obvious.
  localparam int NUM_DIRECTED = 26;
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{MODE_READ,   POL_ANY,          4'd0,  16'h0000, 16'h0000}, 1'b1,
      '{ST_BAD_INDEX, 16'h0, 16'h0, 4'd0, 5'd0}},
    '{'{MODE_DELETE, POL_ANY,          4'd15, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{ST_BAD_INDEX, 16'h0, 16'h0, 4'd0, 5'd0}},
    '{'{MODE_INSERT, POL_ANY,          4'd0,  16'h8000, 16'h1234}, 1'b1,
      '{ST_OK, 16'h0, 16'h0, 4'd0, 5'd1}},
    '{'{MODE_INSERT, POL_UPD_FIRST,    4'd0,  16'h1111, 16'h0001}, 1'b1,
      '{ST_NOT_FOUND, 16'h0, 16'h0, 4'd0, 5'd1}},
    '{'{MODE_INSERT, POL_UPD_LAST,     4'd0,  16'h1111, 16'h0001}, 1'b1,
      '{ST_NOT_FOUND, 16'h0, 16'h0, 4'd0, 5'd1}},
    '{'{MODE_INSERT, POL_UPD_ALL,      4'd0,  16'h1111, 16'h0001}, 1'b1,
      '{ST_NOT_FOUND, 16'h0, 16'h0, 4'd0, 5'd1}},
    '{'{MODE_INSERT, POL_DUPLICATE,    4'd0,  16'h1111, 16'h0001}, 1'b1,
      '{ST_NOT_FOUND, 16'h0, 16'h0, 4'd0, 5'd1}},
    '{'{MODE_INSERT, POL_ANY,          4'd0,  16'h0000, 16'hFFFF}, 1'b0, '0},
    '{'{MODE_INSERT, POL_RESERVED,     4'd0,  16'hFFFF, 16'h0000}, 1'b0, '0},
    '{'{MODE_INSERT, POL_UNIQUE,       4'd0,  16'h8000, 16'h5A5A}, 1'b1,
      '{ST_EXISTS, 16'h0, 16'h0, 4'd0, 5'd3}},
    '{'{MODE_INSERT, POL_DUPLICATE,    4'd0,  16'h8000, 16'h0001}, 1'b0, '0},
    '{'{MODE_INSERT, POL_BEFORE_FIRST, 4'd0,  16'h8000, 16'h0002}, 1'b0, '0},
    '{'{MODE_INSERT, POL_AFTER_LAST,   4'd0,  16'h8000, 16'h0003}, 1'b0, '0},
    '{'{MODE_INSERT, POL_BEFORE_FIRST, 4'd0,  16'h4000, 16'h0004}, 1'b0, '0},
    '{'{MODE_INSERT, POL_AFTER_LAST,   4'd0,  16'hC000, 16'h0005}, 1'b0, '0},
    '{'{MODE_INSERT, POL_UPD_FIRST,    4'd0,  16'h8000, 16'hAAAA}, 1'b0, '0},
    '{'{MODE_INSERT, POL_UPD_LAST,     4'd0,  16'h8000, 16'h5555}, 1'b0, '0},
    '{'{MODE_INSERT, POL_UPD_ALL,      4'd0,  16'h8000, 16'h0F0F}, 1'b0, '0},
    '{'{MODE_INSERT, POL_UPSERT_FIRST, 4'd0,  16'h8000, 16'h0101}, 1'b0, '0},
    '{'{MODE_INSERT, POL_UPSERT_LAST,  4'd0,  16'h8000, 16'h0202}, 1'b0, '0},
    '{'{MODE_INSERT, POL_UPSERT_FIRST, 4'd0,  16'h2000, 16'h2222}, 1'b0, '0},
    '{'{MODE_INSERT, POL_UPSERT_LAST,  4'd0,  16'hE000, 16'hEEEE}, 1'b0, '0},
    '{'{MODE_READ,   POL_ANY,          4'd0,  16'h0000, 16'h0000}, 1'b0, '0},
    '{'{MODE_DELETE, POL_ANY,          4'd1,  16'h0000, 16'h0000}, 1'b0, '0},
    '{'{MODE_READ,   POL_ANY,          4'd15, 16'h0000, 16'h0000}, 1'b0, '0},
    '{'{MODE_CLEAR,  POL_ANY,          4'd0,  16'h0000, 16'h0000}, 1'b1,
      '{ST_OK, 16'h0, 16'h0, 4'd0, 5'd0}}
  };

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [4:0]    cfg_wdata_i;
  logic          in_valid_i;
  logic          in_ready_o;
  mode_t         mode_i;
  policy_t       policy_i;
  logic [3:0]    position_i;
  logic [15:0]   new_key_i;
  logic [15:0]   new_value_i;
  logic          out_valid_o;
  logic          out_ready_i;
  status_t       status_o;
  logic [15:0]   out_key_o;
  logic [15:0]   out_value_o;
  logic [3:0]    where_written_o;
  logic [4:0]    entries_now_o;

  // Predicted table contents and capacity setting.
  logic [15:0]   tbl_key [DEPTH];
  logic [15:0]   tbl_val [DEPTH];
  int            tbl_count;
  int            cap_limit;

  // Replies expected from the block, oldest first.
  table_reply_t  pending_replies [$];

  int            mismatch_count;
  int            reply_count;
  int            quiet_cycles;
  int            out_idle_pct;
  int            mode_seen [4];
  int            status_seen [8];

  sorted_table_insert_engine u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .policy_i        (policy_i),
    .position_i      (position_i),
    .new_key_i       (new_key_i),
    .new_value_i     (new_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .out_key_o       (out_key_o),
    .out_value_o     (out_value_o),
    .where_written_o (where_written_o),
    .entries_now_o   (entries_now_o)
  );

  // Free-running clock with a period of 4.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Applies one transaction to the predicted table and returns the reply it should give.
  function automatic table_reply_t predict_table_reply(table_op_t op);
    table_reply_t rep;
    bit           found;
    bit           do_put;
    int           first;
    int           last;
    int           at;
    int           eff_cap;
    int           i;
    rep = '0;
    rep.status = ST_OK;
    case (op.mode)
      MODE_INSERT: begin
        found = 1'b0;
        first = 0;
        last = 0;
        at = tbl_count;
        for (i = tbl_count - 1; i >= 0; i--) begin
          if (tbl_key[i] > op.key) at = i;
        end
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_key[i] == op.key) begin
            if (!found) first = i;
            found = 1'b1;
            last = i;
          end
        end
        do_put = 1'b0;
        case (op.policy)
          POL_UPD_FIRST, POL_UPSERT_FIRST: begin
            if (found) begin
              tbl_val[first] = op.value;
              rep.where = 4'(first);
            end else if (op.policy == POL_UPD_FIRST) begin
              rep.status = ST_NOT_FOUND;
            end else begin
              do_put = 1'b1;
            end
          end
          POL_UPD_LAST, POL_UPSERT_LAST: begin
            if (found) begin
              tbl_val[last] = op.value;
              rep.where = 4'(last);
            end else if (op.policy == POL_UPD_LAST) begin
              rep.status = ST_NOT_FOUND;
            end else begin
              do_put = 1'b1;
            end
          end
          POL_UPD_ALL: begin
            if (!found) begin
              rep.status = ST_NOT_FOUND;
            end else begin
              for (i = first; i <= last; i++) tbl_val[i] = op.value;
              rep.where = 4'(first);
            end
          end
          POL_UNIQUE: begin
            if (found) rep.status = ST_EXISTS;
            else do_put = 1'b1;
          end
          POL_DUPLICATE: begin
            if (!found) begin
              rep.status = ST_NOT_FOUND;
            end else begin
              do_put = 1'b1;
              at = last + 1;
            end
          end
          POL_BEFORE_FIRST: begin
            do_put = 1'b1;
            if (found) at = first;
          end
          POL_AFTER_LAST: begin
            do_put = 1'b1;
            if (found) at = last + 1;
          end
          default: do_put = 1'b1;
        endcase
        // Every insert that adds an entry is refused once the table holds its capacity.
        if (do_put) begin
          eff_cap = (cap_limit > DEPTH) ? DEPTH : cap_limit;
          if (tbl_count >= eff_cap || tbl_count >= DEPTH) begin
            rep.status = ST_FULL;
          end else begin
            for (i = tbl_count; i > at; i--) begin
              tbl_key[i] = tbl_key[i-1];
              tbl_val[i] = tbl_val[i-1];
            end
            tbl_key[at] = op.key;
            tbl_val[at] = op.value;
            tbl_count++;
            rep.where = 4'(at);
          end
        end
        if (rep.status != ST_OK) rep.where = '0;
      end
      MODE_DELETE, MODE_READ: begin
        if (int'(op.position) >= tbl_count) begin
          rep.status = ST_BAD_INDEX;
        end else begin
          rep.key = tbl_key[op.position];
          rep.value = tbl_val[op.position];
          if (op.mode == MODE_DELETE) begin
            for (i = op.position; i + 1 < tbl_count; i++) begin
              tbl_key[i] = tbl_key[i+1];
              tbl_val[i] = tbl_val[i+1];
            end
            tbl_count--;
          end
        end
      end
      default: tbl_count = 0;
    endcase
    rep.count = 5'(tbl_count);
    return rep;
  endfunction

  // Random transaction; keys are mostly drawn from the table and a few corner values
  // so that the equal-key policies find matches.
  function automatic table_op_t make_random_op(int ins_pct);
    table_op_t op;
    int        r;
    op.value = 16'($urandom);
    op.policy = policy_t'($urandom_range(15));
    r = $urandom_range(99);
    if (r < ins_pct) op.mode = MODE_INSERT;
    else if (r < ins_pct + (97 - ins_pct) / 2) op.mode = MODE_DELETE;
    else if (r < 97) op.mode = MODE_READ;
    else op.mode = MODE_CLEAR;
    r = $urandom_range(99);
    if (r < 40 && tbl_count > 0) begin
      op.key = tbl_key[$urandom_range(tbl_count - 1)];
    end else if (r < 70) begin
      case ($urandom_range(4))
        0: op.key = 16'h0000;
        1: op.key = 16'hFFFF;
        2: op.key = 16'h8000;
        3: op.key = 16'h7FFF;
        default: op.key = 16'($urandom_range(7));
      endcase
    end else begin
      op.key = 16'($urandom);
    end
    if (tbl_count > 0 && $urandom_range(99) < 70) begin
      op.position = 4'($urandom_range(tbl_count - 1));
    end else begin
      op.position = 4'($urandom_range(DEPTH - 1));
    end
    return op;
  endfunction

  // Reports one mismatch and counts it; printing stops after a while.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("mismatch in reply %0d, %s: got %0h, expected %0h",
               reply_count, what, got, exp);
    end
  endtask

  // Presents one transaction from a falling edge and returns at the falling edge after
  // it is accepted, with valid still high.
  task automatic issue_op(input table_op_t op, input int idle_pct, input bit typed,
                          input table_reply_t typed_want);
    table_reply_t want;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    mode_i      = op.mode;
    policy_i    = op.policy;
    position_i  = op.position;
    new_key_i   = op.key;
    new_value_i = op.value;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    want = predict_table_reply(op);
    if (typed) want = typed_want;
    pending_replies.push_back(want);
    mode_seen[op.mode]++;
    status_seen[want.status]++;
    @(negedge clk_i);
  endtask

  // Holds off the sender until every expected reply has come back.
  task automatic wait_table_idle();
    in_valid_i = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Output stalls, changed on the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  // Reply checker: each accepted reply against the oldest expectation.
  always @(posedge clk_i) begin
    table_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      reply_count++;
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with no transaction pending", {29'd0, status_o}, 32'd0);
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) begin
          report_mismatch("status", 32'(status_o), 32'(want.status));
        end
        if (out_key_o !== want.key) begin
          report_mismatch("out_key", 32'(out_key_o), 32'(want.key));
        end
        if (out_value_o !== want.value) begin
          report_mismatch("out_value", 32'(out_value_o), 32'(want.value));
        end
        if (where_written_o !== want.where) begin
          report_mismatch("where_written", 32'(where_written_o), 32'(want.where));
        end
        if (entries_now_o !== want.count) begin
          report_mismatch("entries_now", 32'(entries_now_o), 32'(want.count));
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel completes a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_CYCLES_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", quiet_cycles);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed rows, then random phases under several capacities.
  initial begin
    int cap;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    mode_i = MODE_READ;
    policy_i = POL_ANY;
    position_i = '0;
    new_key_i = '0;
    new_value_i = '0;
    out_ready_i = 1'b0;
    out_idle_pct = 14;
    mismatch_count = 0;
    reply_count = 0;
    quiet_cycles = 0;
    mode_seen = '{default: 0};
    status_seen = '{default: 0};
    tbl_count = 0;
    cap_limit = DEPTH;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      issue_op(DIRECTED_ROWS[r].op, 14, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Capacity changes only while the block is idle.
      wait_table_idle();
      cap = (PHASE_CAP[p] < 0) ? int'($urandom_range(31)) : PHASE_CAP[p];
      cfg_we_i = 1'b1;
      cfg_wdata_i = 5'(cap);
      @(negedge clk_i);
      cfg_we_i = 1'b0;
      cap_limit = cap;
      out_idle_pct = PHASE_IDLE[p];
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        if (p == 0 && n == 60) wait_table_idle();
        issue_op(make_random_op(PHASE_INS_PCT[p]), PHASE_IDLE[p], 1'b0, '0);
      end
    end

    wait_table_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d inserts, %0d deletes, %0d reads, %0d clears in %0d capacity phases",
             mode_seen[MODE_INSERT], mode_seen[MODE_DELETE], mode_seen[MODE_READ],
             mode_seen[MODE_CLEAR], NUM_PHASES);
    $display("replies: %0d ok, %0d full, %0d exists, %0d not found, %0d bad index",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EXISTS],
             status_seen[ST_NOT_FOUND], status_seen[ST_BAD_INDEX]);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sorted_table_insert_engine.f */
+incdir+design
design/stie_pkg.sv
design/stie_ram.sv
design/sorted_table_insert_engine.sv
tb/sorted_table_insert_engine_tb.sv
